### hw/rtl/cfcrc_pkg.sv
package cfcrc_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic MODE_TX = 1'b0;
  localparam logic MODE_CHK = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_CRC = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
    logic       last_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       is_status;
    logic [1:0] status_code;
    logic       last_out;
  } out_word_t;

  typedef struct packed {
    logic has_room;
    logic not_empty;
  } fifo_stat_t;

  // Feed one byte, LSB first, into a left-shifting CRC register.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < BYTE_W; i++) begin
      fb = b[i] ^ c[15];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/cfcrc_res_fifo.sv
module cfcrc_res_fifo
  import cfcrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_cnt,
  input  out_word_t        push_word [MAX_RES],
  input  logic             pop,
  output out_word_t        head_word,
  output fifo_stat_t       stat
);

  out_word_t               mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0]    cnt_r, cnt_nxt;

  assign wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);

  assign head_word      = mem_r[rd_ptr_r];
  assign stat.not_empty = (cnt_r != '0);
  // Leave room for the largest burst one word can cause.
  assign stat.has_room  = (cnt_r <= RES_CNT_W'(RES_DEPTH - MAX_RES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      logic [RES_PTR_W-1:0] rel;
      rel = RES_PTR_W'(i) - wr_ptr_r;
      if (2'(rel) < push_cnt) begin
        mem_r[i] <= push_word[2'(rel)];
      end
    end
  end

endmodule

### hw/rtl/command_frame_crc16_framer_core.sv
// Results: each result word enters the result queue when its input word is accepted.
// Throughput: one input word per cycle; a transmit last byte yields three result words
// that drain one per cycle, while out_stall is low, from a four-entry result queue, and
// input stalls while the queue has fewer than three free entries.
// Reset: synchronous, active low; clears the CRC, the check delay line, the byte count
// and the result queue.
module command_frame_crc16_framer_core
  import cfcrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  // Running CRC and check-mode delay line (entry 0 older).
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  held0_r, held0_nxt;
  logic [7:0]  held1_r, held1_nxt;
  logic [1:0]  seen_r, seen_nxt;

  logic        in_acc;
  logic        out_pop;
  logic [15:0] crc_in;
  logic [15:0] crc_held;
  logic [1:0]  push_cnt;
  out_word_t   push_word [MAX_RES];
  fifo_stat_t  fifo_stat;
  logic [1:0]  code;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = !fifo_stat.has_room;
  assign out_pop  = out_valid && !out_stall;
  assign out_valid = fifo_stat.not_empty;

  // Two CRC updates in parallel: the incoming byte (transmit) and the oldest
  // held byte (check mode).
  assign crc_in   = crc_feed(crc_r, in_word.byte_in);
  assign crc_held = crc_feed(crc_r, held0_r);

  always_comb begin
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    seen_nxt  = seen_r;
    push_cnt  = 2'd0;
    code      = ST_OK;
    for (int i = 0; i < MAX_RES; i++) begin
      push_word[i] = '0;
    end

    if (in_acc) begin
      if (in_word.mode == MODE_TX) begin
        // Pass the byte through; on last append CRC low then high and clear.
        push_word[0].byte_out = in_word.byte_in;
        if (in_word.last_in) begin
          push_word[1].byte_out = crc_in[7:0];
          push_word[2].byte_out = crc_in[15:8];
          push_word[2].last_out = 1'b1;
          push_cnt  = 2'd3;
          crc_nxt   = '0;
          held0_nxt = '0;
          held1_nxt = '0;
          seen_nxt  = '0;
        end else begin
          push_cnt = 2'd1;
          crc_nxt  = crc_in;
        end
      end else if (!in_word.last_in) begin
        // Hold the byte back; the oldest one enters the CRC once the line is full.
        if (seen_r >= 2'd2) begin
          crc_nxt   = crc_held;
          held0_nxt = held1_r;
          held1_nxt = in_word.byte_in;
        end else begin
          if (seen_r[0]) begin
            held1_nxt = in_word.byte_in;
          end else begin
            held0_nxt = in_word.byte_in;
          end
          seen_nxt = seen_r + 2'd1;
        end
      end else begin
        // Compare the two trailing bytes against the CRC of everything before.
        if (seen_r < 2'd2) begin
          code = ST_SHORT;
        end else if ((crc_held[7:0] == held1_r) && (crc_held[15:8] == in_word.byte_in)) begin
          code = ST_OK;
        end else begin
          code = ST_BAD_CRC;
        end
        push_word[0].is_status   = 1'b1;
        push_word[0].status_code = code;
        push_word[0].last_out    = 1'b1;
        push_cnt  = 2'd1;
        crc_nxt   = '0;
        held0_nxt = '0;
        held1_nxt = '0;
        seen_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      held0_r <= '0;
      held1_r <= '0;
      seen_r  <= '0;
    end else begin
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // Result queue decouples the output stall from input acceptance.
  cfcrc_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_word (push_word),
    .pop       (out_pop),
    .head_word (out_word),
    .stat      (fifo_stat)
  );

endmodule

### hw/rtl/cfcrc_chk.sv
module cfcrc_chk
  import cfcrc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_status |-> out_word.last_out && (out_word.byte_out == 8'd0))
    else $error("status word without last mark or with data");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_status |->
      (out_word.status_code == ST_OK) || (out_word.status_code == ST_BAD_CRC) ||
      (out_word.status_code == ST_SHORT))
    else $error("status code out of range");

  a_tx_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.is_status |-> out_word.status_code == ST_OK)
    else $error("transmit word carries a status code");

endmodule

bind command_frame_crc16_framer_core cfcrc_chk u_cfcrc_chk (.*);

### dv/tb_command_frame_crc16_framer_core.sv
`timescale 1ns / 1ps

module tb_command_frame_crc16_framer_core;
  import cfcrc_pkg::*;

  // Tracks the framer state on the side and holds the result words still due.
  class framer_checker;
    logic [15:0] crc_acc;
    logic [7:0]  held_q [2];
    int unsigned held_cnt;
    out_word_t   due_out_words [$];
    int unsigned mismatches;

    function new();
      clear_frame();
      mismatches = 0;
    endfunction

    // One byte into the CRC, bit 0 first; the register shifts toward bit 15.
    static function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[15] ^ b[i];
        c = c << 1;
        if (fb) c = c ^ 16'h8005;
      end
      return c;
    endfunction

    function void clear_frame();
      crc_acc = '0;
      held_q[0] = '0;
      held_q[1] = '0;
      held_cnt = 0;
    endfunction

    function void note_in_word(in_word_t w);
      out_word_t   r;
      logic [15:0] c;
      r = '0;
      if (w.mode == MODE_TX) begin
        crc_acc = crc_byte(crc_acc, w.byte_in);
        r.byte_out = w.byte_in;
        due_out_words.push_back(r);
        if (w.last_in) begin
          r.byte_out = crc_acc[7:0];
          due_out_words.push_back(r);
          r.byte_out = crc_acc[15:8];
          r.last_out = 1'b1;
          due_out_words.push_back(r);
          clear_frame();
        end
      end else if (!w.last_in) begin
        // The two newest check bytes wait in the delay line; the oldest leaves into the CRC.
        if (held_cnt >= 2) begin
          crc_acc = crc_byte(crc_acc, held_q[0]);
          held_q[0] = held_q[1];
          held_q[1] = w.byte_in;
        end else begin
          held_q[held_cnt] = w.byte_in;
          held_cnt++;
        end
      end else begin
        r.is_status = 1'b1;
        r.last_out = 1'b1;
        if (held_cnt < 2) begin
          r.status_code = ST_SHORT;
        end else begin
          c = crc_byte(crc_acc, held_q[0]);
          r.status_code = (c[7:0] == held_q[1] && c[15:8] == w.byte_in) ? ST_OK : ST_BAD_CRC;
        end
        due_out_words.push_back(r);
        clear_frame();
      end
    endfunction

    function void flag(string what, out_word_t want, out_word_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: expected byte=%02h st=%0b code=%0d last=%0b",
                 $time, what, want.byte_out, want.is_status, want.status_code, want.last_out);
        $display("%0t %s: actual   byte=%02h st=%0b code=%0d last=%0b",
                 $time, what, got.byte_out, got.is_status, got.status_code, got.last_out);
      end
    endfunction

    function void check_out_word(out_word_t got);
      out_word_t want;
      if (due_out_words.size() == 0) begin
        flag("unexpected word", '0, got);
        return;
      end
      want = due_out_words.pop_front();
      if (got.byte_out !== want.byte_out || got.is_status !== want.is_status ||
          got.status_code !== want.status_code || got.last_out !== want.last_out)
        flag("mismatch", want, got);
    endfunction
  endclass

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  bit            idle_on = 1'b0;
  int unsigned   words_sent = 0;
  int unsigned   sink_hold = 0;
  framer_checker chk = new();

  command_frame_crc16_framer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // 10 ns clock, low half first.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sink side: stall in bursts of random length while idling is enabled; drop it otherwise.
  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      out_stall <= 1'b1;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      sink_hold <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sample both handshakes at the rising edge: feed accepted input words to the
  // predictor first, then compare any accepted result word with the oldest one due.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) chk.note_in_word(in_word);
      if (out_valid !== 1'b0 && out_stall == 1'b0) chk.check_out_word(out_word);
    end
  end

  // Offer one word from a falling edge, optionally after an idle burst, and hold it
  // until the block takes it. Return at the following falling edge.
  task automatic send_word(input logic md, input logic [7:0] b, input logic lst);
    in_word_t w;
    w.mode = md;
    w.byte_in = b;
    w.last_in = lst;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_byte(fill_t f);
    case (f)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // Transmit frame of n bytes; the block appends the CRC itself.
  task automatic send_tx_frame(input int unsigned n, input fill_t f);
    for (int i = 0; i < n; i++) send_word(MODE_TX, pick_byte(f), i == n - 1);
  endtask

  // Received frame: body bytes, then CRC low and high, the high byte marked last.
  // Flip one CRC bit to build a frame that must fail the check.
  task automatic send_check_frame(input int unsigned n_body, input fill_t f, input bit corrupt);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = '0;
    for (int i = 0; i < n_body; i++) begin
      b = pick_byte(f);
      crc = framer_checker::crc_byte(crc, b);
      send_word(MODE_CHK, b, 1'b0);
    end
    if (corrupt) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    send_word(MODE_CHK, crc[7:0], 1'b0);
    send_word(MODE_CHK, crc[15:8], 1'b1);
  endtask

  initial begin
    int unsigned k;
    int unsigned n;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_on <= 1'b1;

    // Transmit frames at the byte extremes, single byte and longer.
    send_tx_frame(1, FILL_ZERO);
    send_tx_frame(1, FILL_ONES);
    send_tx_frame(3, FILL_RANDOM);
    // Too-short check frames: one byte, then two bytes.
    send_word(MODE_CHK, 8'hFF, 1'b1);
    send_word(MODE_CHK, 8'h00, 1'b0);
    send_word(MODE_CHK, 8'hFF, 1'b1);
    // Shortest valid check frames, good and bad, then one that shifts the delay line.
    send_check_frame(1, FILL_ZERO, 1'b0);
    send_check_frame(1, FILL_ONES, 1'b1);
    send_check_frame(4, FILL_RANDOM, 1'b0);
    // Mode change inside a frame: a transmit byte feeds the CRC ahead of check bytes.
    send_word(MODE_TX, 8'hA5, 1'b0);
    send_check_frame(1, FILL_RANDOM, 1'b0);

    // Mostly well-formed frames with random content, plus loose words as noise.
    // Idle in random stretches; turn idling off for the tail of the run.
    while (words_sent < 300) begin
      idle_on <= (words_sent < 240) && ($urandom_range(0, 3) != 0);
      k = $urandom_range(0, 19);
      if (k < 11) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
        send_check_frame(n, FILL_RANDOM, $urandom_range(0, 2) == 0);
      end else if (k < 16) begin
        send_tx_frame($urandom_range(1, 6), FILL_RANDOM);
      end else begin
        send_word(1'($urandom), 8'($urandom), $urandom_range(0, 2) == 0);
      end
    end

    // Drain: wait for every due word, then keep watching for strays.
    idle_on <= 1'b0;
    in_valid <= 1'b0;
    while (chk.due_out_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (chk.mismatches == 0) begin
      $display("tb_command_frame_crc16_framer_core: PASS");
    end else begin
      $display("tb_command_frame_crc16_framer_core: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("tb_command_frame_crc16_framer_core: FAIL");
    $finish;
  end

endmodule
